// File: sv/fmon_pkg.sv
package fmon_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);

	// field widths
	localparam int MAC_W  = 48;
	localparam int CNT_W  = 32;
	localparam int THR_W  = 16;
	localparam int STAT_W = 2;
	localparam int DCNT_W = $clog2(CNT_W);

	localparam logic [MAC_W-1:0]  BCAST_MAC = {MAC_W{1'b1}};
	localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [THR_W-1:0]  THR_RESET = THR_W'(1);
	localparam logic [DCNT_W-1:0] DIV_LAST  = DCNT_W'(CNT_W - 1);

	// report status codes
	localparam logic [STAT_W-1:0] STAT_RECORDED  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BROADCAST = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MISS,
		ST_UPDATE,
		ST_MOD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [MAC_W-1:0] mac;
		logic [CNT_W-1:0] count;
		logic             notified;
	} entry_t;

endpackage

// File: sv/per_destination_tx_failure_monitor.sv
// channel  | handshake                      | payload
// ---------+--------------------------------+--------------------------------------------
// in       | in_valid / in_stall            | dest_mac, tx_failed
// out      | out_valid / out_stall          | link_failure_notify, notified_mac,
//          |                                | failure_count, report_status
// cfg      | cfg_valid / cfg_ready          | cfg_data (fail_threshold)
//
// one report at a time; a broadcast word goes from acceptance straight to the finish step
// otherwise the lookup reads the table through its single read port, one entry a cycle,
// until a hit on entry k or, for a new destination, past all N occupied entries; then it
// updates or allocates the entry unless the table is full, with the bit-serial remainder unit on a failure
// reset clears the fill count and the threshold (to 1); no clearing pass is needed
// a held result stalls only the finish step; once the result is loaded the next word is
// accepted while it waits
module per_destination_tx_failure_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fmon_pkg::MAC_W-1:0]    dest_mac,
	input  logic                          tx_failed,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          link_failure_notify,
	output logic [fmon_pkg::MAC_W-1:0]    notified_mac,
	output logic [fmon_pkg::CNT_W-1:0]    failure_count,
	output logic [fmon_pkg::STAT_W-1:0]   report_status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fmon_pkg::THR_W-1:0]    cfg_data
);
	import fmon_pkg::*;

	state_t state_q, state_d;

	logic [THR_W-1:0]  thr_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  ent_q;
	logic              out_valid_q;

	logic [MAC_W-1:0]  mac_q;
	logic              failed_q;
	logic [THR_W-1:0]  wthr_q;
	logic [CNT_W-1:0]  old_cnt_q;
	logic              old_ntf_q;
	logic [CNT_W-1:0]  new_cnt_q;

	logic [THR_W-1:0]  div_rem_q;
	logic [CNT_W-1:0]  div_dvd_q;
	logic [DCNT_W-1:0] div_cnt_q;

	logic              res_notify_q;
	logic [CNT_W-1:0]  res_count_q;
	logic [STAT_W-1:0] res_status_q;

	logic              out_notify_q;
	logic [MAC_W-1:0]  out_mac_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [STAT_W-1:0] out_status_q;

	entry_t            mem [TABLE_ENTRIES];
	entry_t            rd_q;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	entry_t            wr_data;

	logic              in_acc;
	logic              out_take;
	logic              out_free;
	logic              hit;
	logic [FILL_W-1:0] idx_next;
	logic              scan_last;
	logic              full;
	logic [CNT_W-1:0]  upd_cnt;
	logic [THR_W:0]    div_trial;
	logic [THR_W-1:0]  div_rem_d;
	logic              div_done;
	logic              mod_zero;

	// handshake terms
	assign in_acc    = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// lookup and allocation terms
	assign hit       = (rd_q.mac == mac_q);
	assign idx_next  = FILL_W'(idx_q) + FILL_W'(1);
	assign scan_last = (idx_next == fill_q);
	assign full      = (fill_q == FILL_W'(TABLE_ENTRIES));

	// count after this report: cleared on success, saturating increment on failure
	always_comb begin
		if (!failed_q) begin
			upd_cnt = '0;
		end else if (old_cnt_q == COUNT_MAX) begin
			upd_cnt = old_cnt_q;
		end else begin
			upd_cnt = old_cnt_q + CNT_W'(1);
		end
	end

	// one restoring remainder step per cycle
	always_comb begin
		div_trial = {div_rem_q, div_dvd_q[CNT_W-1]};
		if (div_trial >= {1'b0, wthr_q}) begin
			div_rem_d = THR_W'(div_trial - {1'b0, wthr_q});
		end else begin
			div_rem_d = div_trial[THR_W-1:0];
		end
	end
	assign div_done = (div_cnt_q == DIV_LAST);
	assign mod_zero = (div_rem_d == '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (dest_mac == BCAST_MAC) begin
						state_d = ST_FINISH;
					end else if (fill_q == '0) begin
						state_d = ST_MISS;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_d = ST_UPDATE;
				end else if (scan_last) begin
					state_d = ST_MISS;
				end
			end
			ST_MISS: begin
				state_d = full ? ST_FINISH : ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = failed_q ? ST_MOD : ST_FINISH;
			end
			ST_MOD: begin
				if (div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs: input stall and table port controls
	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_data  = '{mac: mac_q, count: '0, notified: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				rd_en    = in_valid;
			end
			ST_SCAN: begin
				rd_en   = !hit && !scan_last;
				rd_addr = idx_next[IDX_W-1:0];
			end
			ST_UPDATE: begin
				wr_en = !failed_q;
			end
			ST_MOD: begin
				wr_en   = div_done;
				wr_data = '{mac: mac_q, count: new_cnt_q, notified: old_ntf_q | mod_zero};
			end
			ST_MISS, ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ent_q] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THR_RESET;
			fill_q      <= '0;
			idx_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (state_q == ST_MISS && !full) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (state_q == ST_IDLE) begin
				idx_q <= '0;
			end else if (state_q == ST_SCAN && rd_en) begin
				idx_q <= idx_next[IDX_W-1:0];
			end
			if (state_q == ST_UPDATE) begin
				div_cnt_q <= '0;
			end else if (state_q == ST_MOD) begin
				div_cnt_q <= div_cnt_q + DCNT_W'(1);
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the report in flight
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					mac_q        <= dest_mac;
					failed_q     <= tx_failed;
					wthr_q       <= (thr_q == '0) ? THR_W'(1) : thr_q;
					res_notify_q <= 1'b0;
					res_count_q  <= '0;
					res_status_q <= STAT_BROADCAST;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					ent_q     <= idx_q;
					old_cnt_q <= rd_q.count;
					old_ntf_q <= rd_q.notified;
				end
			end
			ST_MISS: begin
				ent_q        <= fill_q[IDX_W-1:0];
				old_cnt_q    <= '0;
				old_ntf_q    <= 1'b0;
				res_status_q <= STAT_FULL;
			end
			ST_UPDATE: begin
				new_cnt_q    <= upd_cnt;
				div_rem_q    <= '0;
				div_dvd_q    <= upd_cnt;
				res_notify_q <= 1'b0;
				res_count_q  <= '0;
				res_status_q <= STAT_RECORDED;
			end
			ST_MOD: begin
				div_rem_q <= div_rem_d;
				div_dvd_q <= {div_dvd_q[CNT_W-2:0], 1'b0};
				if (div_done) begin
					res_notify_q <= mod_zero;
					res_count_q  <= new_cnt_q;
				end
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_notify_q <= res_notify_q;
			out_mac_q    <= mac_q;
			out_count_q  <= res_count_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign link_failure_notify = out_notify_q;
	assign notified_mac        = out_mac_q;
	assign failure_count       = out_count_q;
	assign report_status       = out_status_q;

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(TABLE_ENTRIES))
		else $error("fill count beyond table size");

	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("fill count moved by more than one");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FINISH))
		else $error("result loaded outside finish step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && report_status != STAT_RECORDED) |->
		(!link_failure_notify && failure_count == '0))
		else $error("unrecorded report carries a count or notification");

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (ent_q < fill_q))
		else $error("table write outside allocated entries");

endmodule
